@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define BED_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define BED_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define BED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BED_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define BED_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BED_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/bed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bed_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_M         = 8'h6D;
  localparam logic [7:0] CH_ESC       = 8'd27;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] TALLY_MAX    = 8'd255;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX1   = 4'b0100,
    MODE_HEX2   = 4'b1000
  } mode_t;

  // what the back end has to do with one queued word
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_CRLF = 2'd1,
    OP_END  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        bad;
    logic [7:0]  count;
  } entry_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  tally;
  } front_status_t;

  typedef struct packed {
    logic        pend_lf;
  } back_status_t;

  // {bad, value}; a non-hex digit reads as zero with bad set
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'b10000;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b0, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b0, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  // single-byte escapes; anything unlisted passes through
  function automatic logic [7:0] esc_map(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      8'h61: r = 8'd7;   // a
      8'h62: r = 8'd8;   // b
      8'h65: r = CH_ESC; // e
      8'h66: r = 8'd12;  // f
      8'h6C: r = CH_LF;  // l
      8'h6E: r = CH_LF;  // n
      8'h71: r = 8'd34;  // q
      8'h72: r = CH_CR;  // r
      8'h74: r = 8'd9;   // t
      8'h76: r = 8'd11;  // v
      8'h7A: r = 8'd0;   // z
      8'h22: r = 8'd34;  // double quote
      default: r = ch;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/backslash_escape_decoder.sv @@
// Backslash escape decoder, one raw string byte per input word.
// Input channel: in_valid/in_ready with in_byte and end_of_string. A word
// with end_of_string set closes the string and yields one closing word
// (is_end=1, removed_count = bytes dropped, saturating at 255); any escape
// still open at that point is dropped.
// Output channel: out_valid/out_ready with out_byte, is_end, removed_count
// and bad_hex. Most input words give one output word, a backslash, an x
// escape or its first digit give none, and \m gives two (CR, then LF).
// The classifier writes each entry into the queue at the edge that takes its
// input word; the output register then loads it from the queue head once the
// register is free or its word leaves.
// Throughput: one input word per cycle while the queue is not full; the output
// register emits one word per cycle while the receiver is ready.
// Between the classifier and the output stage sits a QUEUE_DEPTH-word
// queue. When the receiver stalls, the queue fills and in_ready drops only
// when it is full.
// Reset (synchronous) clears the decode mode, the removed tally, the queue
// and the output valid flag; in_ready is low during reset and the block
// accepts words the cycle after.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module backslash_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            is_end,
  output logic [7:0]      removed_count,
  output logic            bad_hex
);
  import bed_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t          push_entry, head;
  logic            push, q_full, pop, head_valid;
  logic [CNT_W-1:0] q_count;
  front_status_t   front_st;
  back_status_t    back_st;
  logic            end_taken, front_clear, cr_shown;

  bed_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry),
    .status       (front_st)
  );

  bed_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  bed_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_end       (is_end),
    .removed_count(removed_count),
    .bad_hex      (bad_hex),
    .status       (back_st)
  );

  assign end_taken   = in_valid && in_ready && end_of_string;
  assign front_clear = (front_st.mode == MODE_NORMAL) && (front_st.tally == 8'd0);
  assign cr_shown    = out_valid && (out_byte == CH_CR) && !is_end;

  `BED_ASSERT_ALWAYS(a_queue_bound, clk, rst, q_count <= CNT_W'(QUEUE_DEPTH))
  `BED_ASSERT_NEXT(a_end_clears, clk, rst, end_taken, front_clear)
  `BED_ASSERT_IMPL(a_lf_after_cr, clk, rst, back_st.pend_lf, cr_shown)
  `BED_ASSERT_IMPL(a_end_word_clean, clk, rst, out_valid && is_end, out_byte == 8'd0 && !bad_hex)

endmodule

`default_nettype wire

@@ hw/rtl/bed_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bed_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   end_of_string,
  input  wire logic                   q_full,
  output logic                        push,
  output bed_pkg::entry_t             push_entry,
  output bed_pkg::front_status_t      status
);
  import bed_pkg::*;

  mode_t      mode, mode_next;
  logic [3:0] nibble, nibble_next;
  logic       first_bad, first_bad_next;
  logic [7:0] tally, tally_next;
  logic [7:0] tally_inc, tally_dec;
  logic [4:0] hv;
  logic       accept;

  // hold off input while in reset so no word is taken and then dropped
  assign in_ready = !q_full && !rst;
  assign accept   = in_valid && in_ready;
  assign hv       = hex_value(in_byte);
  assign status   = '{mode: mode, tally: tally};

  // saturate up; a saturated tally stays put on the way down
  assign tally_inc = (tally == TALLY_MAX) ? tally : tally + 8'd1;
  assign tally_dec = (tally != 8'd0 && tally != TALLY_MAX) ? tally - 8'd1 : tally;

  always_comb begin
    mode_next      = mode;
    nibble_next    = nibble;
    first_bad_next = first_bad;
    tally_next     = tally;
    push           = 1'b0;
    push_entry     = '0;
    push_entry.kind = OP_BYTE;
    if (accept) begin
      if (end_of_string) begin
        push             = 1'b1;
        push_entry.kind  = OP_END;
        push_entry.count = tally;
        mode_next        = MODE_NORMAL;
        nibble_next      = 4'd0;
        first_bad_next   = 1'b0;
        tally_next       = 8'd0;
      end else begin
        unique case (mode)
          MODE_NORMAL: begin
            if (in_byte == CH_BACKSLASH) begin
              mode_next  = MODE_ESCAPE;
              tally_next = tally_inc;
            end else begin
              push            = 1'b1;
              push_entry.data = in_byte;
            end
          end
          MODE_ESCAPE: begin
            mode_next = MODE_NORMAL;
            if (in_byte == CH_M) begin
              push            = 1'b1;
              push_entry.kind = OP_CRLF;
              tally_next      = tally_dec;
            end else if (in_byte == CH_X) begin
              mode_next  = MODE_HEX1;
              tally_next = tally_inc;
            end else begin
              push            = 1'b1;
              push_entry.data = esc_map(in_byte);
            end
          end
          MODE_HEX1: begin
            nibble_next    = hv[3:0];
            first_bad_next = hv[4];
            mode_next      = MODE_HEX2;
            tally_next     = tally_inc;
          end
          MODE_HEX2: begin
            push            = 1'b1;
            push_entry.data = {nibble, hv[3:0]};
            push_entry.bad  = first_bad | hv[4];
            mode_next       = MODE_NORMAL;
            nibble_next     = 4'd0;
            first_bad_next  = 1'b0;
          end
          default: mode_next = MODE_NORMAL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      nibble    <= 4'd0;
      first_bad <= 1'b0;
      tally     <= 8'd0;
    end else begin
      mode      <= mode_next;
      nibble    <= nibble_next;
      first_bad <= first_bad_next;
      tally     <= tally_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bed_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bed_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire bed_pkg::entry_t          push_entry,
  output logic                          full,
  input  wire logic                     pop,
  output logic                          head_valid,
  output bed_pkg::entry_t               head,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import bed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bed_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bed_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire bed_pkg::entry_t       head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       is_end,
  output logic [7:0]                 removed_count,
  output logic                       bad_hex,
  output bed_pkg::back_status_t      status
);
  import bed_pkg::*;

  logic pend_lf;
  logic load;

  // output register is free, or its word leaves this cycle
  assign load   = !out_valid || out_ready;
  assign pop    = load && !pend_lf && head_valid;
  assign status = '{pend_lf: pend_lf};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_lf   <= 1'b0;
    end else if (load) begin
      if (pend_lf) begin
        out_valid <= 1'b1;
        pend_lf   <= 1'b0;
      end else begin
        out_valid <= head_valid;
        pend_lf   <= head_valid && (head.kind == OP_CRLF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_lf) begin
        out_byte      <= CH_LF;
        is_end        <= 1'b0;
        removed_count <= 8'd0;
        bad_hex       <= 1'b0;
      end else begin
        case (head.kind)
          OP_CRLF: begin
            out_byte      <= CH_CR;
            is_end        <= 1'b0;
            removed_count <= 8'd0;
            bad_hex       <= 1'b0;
          end
          OP_END: begin
            out_byte      <= 8'd0;
            is_end        <= 1'b1;
            removed_count <= head.count;
            bad_hex       <= 1'b0;
          end
          default: begin
            out_byte      <= head.data;
            is_end        <= 1'b0;
            removed_count <= 8'd0;
            bad_hex       <= head.bad;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bed_pkg::*;

  localparam int ITEMS_PER_PHASE = 300;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_PRINTS      = 100;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic [7:0] count;
    logic       bad;
  } dec_word_t;

  // Tracks the decoder state and holds the words it must still emit.
  class decode_tracker;
    mode_t      mode;
    logic [7:0] tally;
    logic [3:0] hi_nib;
    logic       hi_bad;
    dec_word_t  expected_words[$];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      mode   = MODE_NORMAL;
      tally  = 8'd0;
      hi_nib = 4'd0;
      hi_bad = 1'b0;
    endfunction

    function void push_word(logic [7:0] data, logic fin, logic [7:0] count, logic bad);
      dec_word_t w;
      w.data  = data;
      w.fin   = fin;
      w.count = count;
      w.bad   = bad;
      expected_words.push_back(w);
    endfunction

    function void bump_tally();
      if (tally != TALLY_MAX) tally = tally + 8'd1;
    endfunction

    // {bad, value}; non-hex reads as zero
    function logic [4:0] digit_value(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
      if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 8'd10)};
      if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
      return 5'b10000;
    endfunction

    function void take_input(logic [7:0] ch, logic eos);
      logic [4:0] dv;
      logic [7:0] v;
      if (eos) begin
        push_word(8'd0, 1'b1, tally, 1'b0);
        clear_state();
        return;
      end
      case (mode)
        MODE_NORMAL: begin
          if (ch == CH_BACKSLASH) begin
            mode = MODE_ESCAPE;
            bump_tally();
          end else begin
            push_word(ch, 1'b0, 8'd0, 1'b0);
          end
        end
        MODE_ESCAPE: begin
          mode = MODE_NORMAL;
          if (ch == CH_M) begin
            // a saturated tally stays put
            if (tally != TALLY_MAX && tally != 8'd0) tally = tally - 8'd1;
            push_word(CH_CR, 1'b0, 8'd0, 1'b0);
            push_word(CH_LF, 1'b0, 8'd0, 1'b0);
          end else if (ch == CH_X) begin
            mode = MODE_HEX1;
            bump_tally();
          end else begin
            case (ch)
              "a":     v = 8'd7;
              "b":     v = 8'd8;
              "e":     v = CH_ESC;
              "f":     v = 8'd12;
              "l":     v = CH_LF;
              "n":     v = CH_LF;
              "q":     v = 8'd34;
              "r":     v = CH_CR;
              "t":     v = 8'd9;
              "v":     v = 8'd11;
              "z":     v = 8'd0;
              8'h22:   v = 8'd34;
              default: v = ch;
            endcase
            push_word(v, 1'b0, 8'd0, 1'b0);
          end
        end
        MODE_HEX1: begin
          dv     = digit_value(ch);
          hi_nib = dv[3:0];
          hi_bad = dv[4];
          mode   = MODE_HEX2;
          bump_tally();
        end
        default: begin
          dv = digit_value(ch);
          push_word({hi_nib, dv[3:0]}, 1'b0, 8'd0, hi_bad | dv[4]);
          mode   = MODE_NORMAL;
          hi_nib = 4'd0;
          hi_bad = 1'b0;
        end
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function string check_word(logic [7:0] data, logic fin, logic [7:0] count, logic bad);
      dec_word_t w;
      string     msg;
      if (expected_words.size() == 0)
        return $sformatf("unexpected word out_byte=%02h is_end=%0b removed_count=%0d",
                         data, fin, count);
      w   = expected_words.pop_front();
      msg = "";
      if (data !== w.data)  msg = {msg, $sformatf(" out_byte %02h/%02h", data, w.data)};
      if (fin !== w.fin)    msg = {msg, $sformatf(" is_end %0b/%0b", fin, w.fin)};
      if (count !== w.count) msg = {msg, $sformatf(" removed_count %0d/%0d", count, w.count)};
      if (bad !== w.bad)    msg = {msg, $sformatf(" bad_hex %0b/%0b", bad, w.bad)};
      if (msg != "") msg = {"word mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       is_end;
  logic [7:0] removed_count;
  logic       bad_hex;

  decode_tracker tracker = new();
  int  errors = 0;
  int  n_sent = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  holding = 1'b0;
  event hold_go;

  backslash_escape_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_end        (is_end),
    .removed_count (removed_count),
    .bad_hex       (bad_hex)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // receiver: random stalls, forced low during a hold-off
  always @(negedge clk) begin
    out_ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
  end

  always begin
    @(hold_go);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      msg = tracker.check_word(out_byte, is_end, removed_count, bad_hex);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_input(b, eos);
    n_sent++;
  endtask

  // wait until every expected word is out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] maybe_bad_hex();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return rand_hex();
  endfunction

  // one string: plain bytes and escapes, closed by an end word; now and
  // then the last escape is left open
  task automatic send_string(input int tokens, input int hex_pct);
    logic [7:0] esc_chars[17] = '{"a", "b", "e", "f", "l", "n", "q", "r", "t", "v",
                                  "z", 8'h22, CH_M, CH_X, CH_BACKSLASH, 8'h00, 8'h00};
    int r;
    int k;
    logic [7:0] c;
    for (int i = 0; i < tokens; i++) begin
      r = $urandom_range(0, 99);
      if (r < hex_pct) begin
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_X, 1'b0);
        send_word(maybe_bad_hex(), 1'b0);
        send_word(maybe_bad_hex(), 1'b0);
      end else if (r < hex_pct + (100 - hex_pct) / 2) begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        k = $urandom_range(0, 16);
        c = (k >= 15) ? 8'($urandom_range(0, 255)) : esc_chars[k];
        send_word(CH_BACKSLASH, 1'b0);
        send_word(c, 1'b0);
        if (c == CH_X) begin
          send_word(maybe_bad_hex(), 1'b0);
          send_word(maybe_bad_hex(), 1'b0);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      send_word(CH_BACKSLASH, 1'b0);
      k = $urandom_range(0, 2);
      if (k > 0) send_word(CH_X, 1'b0);
      if (k > 1) send_word(rand_hex(), 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int target;
    int phase_start;
    bit held;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: byte extremes, CR/LF escape, escaped backslash, hex cases,
    // open escapes at the end of a string
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_M, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_X, 1'b0);
    send_word("4", 1'b0);
    send_word("F", 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_X, 1'b0);
    send_word("G", 1'b0);
    send_word("1", 1'b0);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_X, 1'b0);
    send_word("a", 1'b0);
    send_word("Z", 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(CH_BACKSLASH, 1'b0);
    send_word(CH_X, 1'b0);
    send_word("3", 1'b0);
    send_word(8'h5A, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      phase_start = n_sent;
      target = n_sent + ITEMS_PER_PHASE;
      held = 1'b0;
      // long hex-heavy string to push the removed count into saturation
      if (p == 1 || p == 3) send_string(95, 95);
      while (n_sent < target) begin
        send_string($urandom_range(0, 12), 15);
        if (p == 0 && !held && n_sent > phase_start + 100) begin
          -> hold_go;
          held = 1'b1;
        end
        if (p == 2 && $urandom_range(0, 19) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
